/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rcsfc check failed");

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("rcsfc check failed");

`endif

/* hdl/rcsfc_pkg.sv */
// Package for the stick frame conditioner: widths, constants, register codes and word types.
package rcsfc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int STICK_W     = 12;
  localparam int THRUST_W    = 10;
  localparam int BATT_W      = 10;
  localparam int MV_W        = 12;
  localparam int MODE_W      = 3;
  localparam int TRIM_W      = STICK_W + 1;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [STICK_W-1:0]  STICK_SPAN  = STICK_W'(3000);
  localparam logic [THRUST_W-1:0] THRUST_SPAN = THRUST_W'(1000);
  localparam logic [BATT_W-1:0]   BATT_MAX    = BATT_W'(819);

  // floor(mv / 5) = (mv * 3277) >> 14 for every 12-bit mv
  localparam int BATT_RECIP = 3277;
  localparam int BATT_SHIFT = 14;

  localparam logic [STICK_W-1:0]  CENTER_RESET     = STICK_W'(1500);
  localparam logic [THRUST_W-1:0] LOCK_LIMIT_RESET = THRUST_W'(10);
  localparam logic [MODE_W-1:0]   MODE_COUNT_RESET = MODE_W'(3);
  localparam logic [MODE_W-1:0]   MODE_FIRST       = MODE_W'(1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CENTER_VALUE      = 2'd0,
    REG_LOCK_THRUST_LIMIT = 2'd1,
    REG_MODE_COUNT        = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [STICK_W-1:0]  center_value;
    logic [THRUST_W-1:0] lock_thrust_limit;
    logic [MODE_W-1:0]   mode_count;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] roll_raw;
    logic [SAMPLE_BITS-1:0] pitch_raw;
    logic [SAMPLE_BITS-1:0] yaw_raw;
    logic [SAMPLE_BITS-1:0] thrust_raw;
    logic [MV_W-1:0]        battery_mv;
    logic                   button_one;
    logic                   button_two;
    logic                   button_three;
    logic                   button_four;
    logic                   trim_request;
  } in_word_t;

  typedef struct packed {
    logic [STICK_W-1:0]  roll_out;
    logic [STICK_W-1:0]  pitch_out;
    logic [STICK_W-1:0]  yaw_out;
    logic [THRUST_W-1:0] thrust_out;
    logic [BATT_W-1:0]   battery_out;
    logic                aux_one;
    logic                aux_two;
    logic                aux_three;
    logic                aux_four;
    logic                locked;
    logic [MODE_W-1:0]   flight_mode;
  } out_word_t;

  typedef struct packed {
    logic [STICK_W-1:0]  roll;
    logic [STICK_W-1:0]  pitch;
    logic [STICK_W-1:0]  yaw;
    logic [THRUST_W-1:0] thrust;
    logic [BATT_W-1:0]   battery;
  } scaled_t;

  typedef struct packed {
    logic [STICK_W-1:0] roll;
    logic [STICK_W-1:0] pitch;
    logic [STICK_W-1:0] yaw;
    logic               locked;
    logic [MODE_W-1:0]  flight_mode;
  } frame_state_t;

endpackage

/* hdl/rcsfc_scale.sv */
// Constant scaling of the stick samples and battery reading.
module rcsfc_scale
  import rcsfc_pkg::*;
(
  input  in_word_t word,
  output scaled_t  scaled
);

  localparam int PROD_W = SAMPLE_BITS + STICK_W;
  localparam int BPROD_W = MV_W + 12;

  // floor(x / (2^n - 1)) as (x + (x >> n) + 1) >> n
  function automatic logic [STICK_W-1:0] div_raw_max(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + (PROD_W+1)'(x >> SAMPLE_BITS) + (PROD_W+1)'(1);
    return STICK_W'(t >> SAMPLE_BITS);
  endfunction

  function automatic logic [STICK_W-1:0] scale_stick(input logic [SAMPLE_BITS-1:0] raw);
    return div_raw_max(PROD_W'(raw) * PROD_W'(STICK_SPAN));
  endfunction

  logic [STICK_W-1:0] thrust_full;
  logic [BPROD_W-1:0] batt_prod;

  assign thrust_full = div_raw_max(PROD_W'(word.thrust_raw) * PROD_W'(THRUST_SPAN));
  assign batt_prod   = BPROD_W'(word.battery_mv) * BPROD_W'(BATT_RECIP);

  always_comb begin
    scaled.roll  = scale_stick(word.roll_raw);
    scaled.pitch = scale_stick(word.pitch_raw);
    scaled.yaw   = scale_stick(word.yaw_raw);
    if (thrust_full > STICK_W'(THRUST_SPAN)) begin
      scaled.thrust = THRUST_SPAN;
    end else begin
      scaled.thrust = thrust_full[THRUST_W-1:0];
    end
    scaled.battery = BATT_W'(batt_prod >> BATT_SHIFT);
  end

endmodule

/* hdl/rcsfc_ctrl.sv */
// Trim capture, trimmed stick clamps, lock toggle and flight-mode stepping.
module rcsfc_ctrl
  import rcsfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  in_word_t     word,
  input  scaled_t      scaled,
  input  cfg_t         cfg,
  output frame_state_t frame
);

  localparam int DIFF_W = TRIM_W + 1;

  logic                     trim_pending;
  logic signed [TRIM_W-1:0] roll_trim;
  logic signed [TRIM_W-1:0] pitch_trim;
  logic signed [TRIM_W-1:0] yaw_trim;
  logic                     last_button_one;
  logic                     last_button_three;
  logic                     lock_flag;
  logic [MODE_W-1:0]        mode_counter;

  logic                     capture;
  logic signed [TRIM_W-1:0] roll_trim_next;
  logic signed [TRIM_W-1:0] pitch_trim_next;
  logic signed [TRIM_W-1:0] yaw_trim_next;
  logic                     lock_flag_next;
  logic [MODE_W-1:0]        mode_counter_next;
  logic [MODE_W:0]          mode_inc;

  function automatic logic signed [TRIM_W-1:0] take_offset(
    input logic [STICK_W-1:0] value,
    input logic [STICK_W-1:0] center
  );
    return $signed({1'b0, value}) - $signed({1'b0, center});
  endfunction

  function automatic logic [STICK_W-1:0] apply_trim(
    input logic [STICK_W-1:0]        value,
    input logic signed [TRIM_W-1:0]  trim
  );
    logic signed [DIFF_W-1:0] diff;
    diff = $signed({2'b00, value}) - DIFF_W'(trim);
    if (diff < 0) begin
      return '0;
    end else if (diff > $signed({2'b00, STICK_SPAN})) begin
      return STICK_SPAN;
    end else begin
      return diff[STICK_W-1:0];
    end
  endfunction

  assign capture  = trim_pending | word.trim_request;
  assign mode_inc = {1'b0, mode_counter} + (MODE_W+1)'(1);

  always_comb begin
    if (capture) begin
      roll_trim_next  = take_offset(scaled.roll, cfg.center_value);
      pitch_trim_next = take_offset(scaled.pitch, cfg.center_value);
      yaw_trim_next   = take_offset(scaled.yaw, cfg.center_value);
    end else begin
      roll_trim_next  = roll_trim;
      pitch_trim_next = pitch_trim;
      yaw_trim_next   = yaw_trim;
    end

    lock_flag_next = lock_flag ^ (last_button_one & ~word.button_one &
                                  (scaled.thrust <= cfg.lock_thrust_limit));

    mode_counter_next = mode_counter;
    if (last_button_three & ~word.button_three) begin
      if (mode_inc > {1'b0, cfg.mode_count}) begin
        mode_counter_next = MODE_FIRST;
      end else begin
        mode_counter_next = mode_inc[MODE_W-1:0];
      end
    end

    frame.roll        = apply_trim(scaled.roll, roll_trim_next);
    frame.pitch       = apply_trim(scaled.pitch, pitch_trim_next);
    frame.yaw         = apply_trim(scaled.yaw, yaw_trim_next);
    frame.locked      = lock_flag_next;
    frame.flight_mode = mode_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_pending      <= 1'b1;
      roll_trim         <= '0;
      pitch_trim        <= '0;
      yaw_trim          <= '0;
      last_button_one   <= 1'b0;
      last_button_three <= 1'b0;
      lock_flag         <= 1'b0;
      mode_counter      <= MODE_FIRST;
    end else if (step) begin
      trim_pending      <= 1'b0;
      roll_trim         <= roll_trim_next;
      pitch_trim        <= pitch_trim_next;
      yaw_trim          <= yaw_trim_next;
      last_button_one   <= word.button_one;
      last_button_three <= word.button_three;
      lock_flag         <= lock_flag_next;
      mode_counter      <= mode_counter_next;
    end
  end

endmodule

/* hdl/rc_stick_frame_conditioner_core.sv */
// Top level of the stick frame conditioner: input register, frame logic, result register.
//
//   channel  signals                          direction  word
//   in       in_valid in_ready in_data         sink       in_word_t
//   out      out_valid out_ready out_data      source     out_word_t
//   cfg      cfg_write cfg_index cfg_data      sink       one register per write
//
// One word per cycle while out_ready is high; a word passes input, then result register.
// The path from the input register through the constant multiplies, trim clamp
// and mode/lock logic to the result register sets the cycle time.
// Synchronous reset empties both stages, zeroes trim and lock, resets mode and registers.
// A stalled result holds; the input register keeps taking words until it is full.
module rc_stick_frame_conditioner_core
  import rcsfc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t         cfg;
  logic         hold_valid;
  in_word_t     hold;
  logic         advance;
  scaled_t      scaled;
  frame_state_t frame;
  out_word_t    result_next;

  assign advance  = hold_valid & (~out_valid | out_ready);
  assign in_ready = ~hold_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_value      <= CENTER_RESET;
      cfg.lock_thrust_limit <= LOCK_LIMIT_RESET;
      cfg.mode_count        <= MODE_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_VALUE:      cfg.center_value      <= cfg_data[STICK_W-1:0];
        REG_LOCK_THRUST_LIMIT: cfg.lock_thrust_limit <= cfg_data[THRUST_W-1:0];
        REG_MODE_COUNT:        cfg.mode_count        <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready & in_valid) begin
      hold <= in_data;
    end
  end

  rcsfc_scale u_scale (
    .word   (hold),
    .scaled (scaled)
  );

  rcsfc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (hold),
    .scaled (scaled),
    .cfg    (cfg),
    .frame  (frame)
  );

  always_comb begin
    result_next.roll_out    = frame.roll;
    result_next.pitch_out   = frame.pitch;
    result_next.yaw_out     = frame.yaw;
    result_next.thrust_out  = scaled.thrust;
    result_next.battery_out = scaled.battery;
    result_next.aux_one     = hold.button_one;
    result_next.aux_two     = hold.button_two;
    result_next.aux_three   = hold.button_three;
    result_next.aux_four    = hold.button_four;
    result_next.locked      = frame.locked;
    result_next.flight_mode = frame.flight_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

endmodule

/* hdl/rcsfc_checker.sv */
// Port-level checks for the stick frame conditioner, bound to the top level.
`include "assert_macros.svh"

module rcsfc_checker
  import rcsfc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  `ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)
  `ASSERT_RUN(a_sticks_range, out_valid |-> out_data.roll_out <= STICK_SPAN && out_data.pitch_out <= STICK_SPAN && out_data.yaw_out <= STICK_SPAN)
  `ASSERT_RUN(a_thrust_batt_range, out_valid |-> out_data.thrust_out <= THRUST_SPAN && out_data.battery_out <= BATT_MAX)
  `ASSERT_RUN(a_mode_nonzero, out_valid |-> out_data.flight_mode != '0)

endmodule

bind rc_stick_frame_conditioner_core rcsfc_checker u_rcsfc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/rc_stick_frame_conditioner_core_tb.sv */
// Testbench for the stick frame conditioner core: directed frames, register phases, random frames.
module rc_stick_frame_conditioner_core_tb;
  import rcsfc_pkg::*;

  localparam int RAW_MAX     = (1 << SAMPLE_BITS) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AT     = 300;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 130;
  localparam int CALM_PHASE  = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    in_word_t  frame;
    logic      known;
    out_word_t want;
  } dir_row_t;

  localparam int NDIR = 21;
  localparam dir_row_t DIR_TAB [NDIR] = '{
    '{'{12'd2048, 12'd2048, 12'd2048, 12'd0, 12'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b1,
      '{12'd1500, 12'd1500, 12'd1500, 10'd0, 10'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 3'd1}},
    '{'{12'd0, 12'd0, 12'd0, 12'd4095, 12'd4095, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{12'd0, 12'd0, 12'd0, 10'd1000, 10'd819, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 3'd1}},
    '{'{12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd3300, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b1,
      '{12'd3000, 12'd3000, 12'd3000, 10'd0, 10'd660, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 3'd1}},
    '{'{12'd2048, 12'd2048, 12'd2048, 12'd0, 12'd1000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b1,
      '{12'd1500, 12'd1500, 12'd1500, 10'd0, 10'd200, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 3'd1}},
    '{'{12'd2048, 12'd2048, 12'd2048, 12'd0, 12'd1000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b1,
      '{12'd1500, 12'd1500, 12'd1500, 10'd0, 10'd200, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 3'd1}},
    '{'{12'd1024, 12'd3072, 12'd512, 12'd4095, 12'd5, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd2048, 12'd2048, 12'd2048, 12'd45, 12'd9, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{12'd2048, 12'd2048, 12'd2048, 12'd45, 12'd9, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{12'd2048, 12'd2048, 12'd2048, 12'd46, 12'd9, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{12'd2048, 12'd2048, 12'd2048, 12'd46, 12'd9, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{12'd100, 12'd200, 12'd300, 12'd2000, 12'd1234, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{12'd100, 12'd200, 12'd300, 12'd2000, 12'd1234, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{12'd100, 12'd200, 12'd300, 12'd2000, 12'd1234, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd100, 12'd200, 12'd300, 12'd2000, 12'd1234, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd100, 12'd200, 12'd300, 12'd2000, 12'd1234, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{12'd0, 12'd0, 12'd0, 12'd10, 12'd3299, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{12'd4095, 12'd4095, 12'd4095, 12'd10, 12'd3299, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd4095, 12'd4095, 12'd4095, 12'd10, 12'd1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{12'd0, 12'd0, 12'd0, 12'd10, 12'd1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0}
  };

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  in_word_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_word_t              out_data;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rc_stick_frame_conditioner_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of registers and frame state
  logic [STICK_W-1:0]        center_reg;
  logic [THRUST_W-1:0]       limit_reg;
  logic [MODE_W-1:0]         modes_reg;
  bit                        trim_armed;
  logic signed [TRIM_W-1:0]  roll_ofs;
  logic signed [TRIM_W-1:0]  pitch_ofs;
  logic signed [TRIM_W-1:0]  yaw_ofs;
  bit                        prev_b1;
  bit                        prev_b3;
  bit                        lock_st;
  logic [MODE_W-1:0]         mode_st;

  out_word_t frame_q[$];
  out_word_t head_w;
  int        mismatches;
  int        words_seen;
  int        cycle_count;
  int        hold_left;
  bit        held;
  bit        calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int scale_raw(logic [SAMPLE_BITS-1:0] raw, int span);
    return (int'(raw) * span) / RAW_MAX;
  endfunction

  function automatic logic [STICK_W-1:0] trim_clamp(int s, logic signed [TRIM_W-1:0] ofs);
    int v;
    v = s - int'(ofs);
    if (v < 0) v = 0;
    if (v > int'(STICK_SPAN)) v = int'(STICK_SPAN);
    return STICK_W'(v);
  endfunction

  function automatic out_word_t predict_frame(in_word_t w);
    int        r;
    int        p;
    int        y;
    int        t;
    int        nxt;
    out_word_t o;
    r = scale_raw(w.roll_raw, int'(STICK_SPAN));
    p = scale_raw(w.pitch_raw, int'(STICK_SPAN));
    y = scale_raw(w.yaw_raw, int'(STICK_SPAN));
    t = scale_raw(w.thrust_raw, int'(THRUST_SPAN));
    if (trim_armed || w.trim_request) begin
      roll_ofs   = TRIM_W'(r - int'(center_reg));
      pitch_ofs  = TRIM_W'(p - int'(center_reg));
      yaw_ofs    = TRIM_W'(y - int'(center_reg));
      trim_armed = 1'b0;
    end
    if (t > int'(THRUST_SPAN)) t = int'(THRUST_SPAN);
    if (prev_b1 && !w.button_one && t <= int'(limit_reg)) lock_st = !lock_st;
    prev_b1 = w.button_one;
    if (prev_b3 && !w.button_three) begin
      nxt = int'(mode_st) + 1;
      if (nxt > int'(modes_reg)) nxt = 1;
      mode_st = MODE_W'(nxt);
    end
    prev_b3 = w.button_three;
    o.roll_out    = trim_clamp(r, roll_ofs);
    o.pitch_out   = trim_clamp(p, pitch_ofs);
    o.yaw_out     = trim_clamp(y, yaw_ofs);
    o.thrust_out  = THRUST_W'(t);
    o.battery_out = BATT_W'((int'(w.battery_mv) * 2) / 10);
    o.aux_one     = w.button_one;
    o.aux_two     = w.button_two;
    o.aux_three   = w.button_three;
    o.aux_four    = w.button_four;
    o.locked      = lock_st;
    o.flight_mode = mode_st;
    return o;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] stick_pick();
    int k;
    k = $urandom_range(7);
    if (k == 0) return '0;
    if (k == 1) return SAMPLE_BITS'(RAW_MAX);
    return SAMPLE_BITS'($urandom_range(RAW_MAX));
  endfunction

  function automatic in_word_t make_frame();
    in_word_t f;
    int       lim_raw;
    lim_raw = (int'(limit_reg) * RAW_MAX) / 1000 + 8;
    if (lim_raw > RAW_MAX) lim_raw = RAW_MAX;
    f.roll_raw     = stick_pick();
    f.pitch_raw    = stick_pick();
    f.yaw_raw      = stick_pick();
    f.thrust_raw   = ($urandom_range(99) < 40) ? SAMPLE_BITS'($urandom_range(lim_raw))
                                               : SAMPLE_BITS'($urandom_range(RAW_MAX));
    f.battery_mv   = ($urandom_range(4) == 0) ? MV_W'($urandom_range(4095))
                                              : MV_W'($urandom_range(3300));
    f.button_one   = 1'($urandom_range(1));
    f.button_two   = 1'($urandom_range(1));
    f.button_three = 1'($urandom_range(1));
    f.button_four  = 1'($urandom_range(1));
    f.trim_request = ($urandom_range(15) == 0);
    return f;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    case (idx)
      REG_CENTER_VALUE:      center_reg = d[STICK_W-1:0];
      REG_LOCK_THRUST_LIMIT: limit_reg  = d[THRUST_W-1:0];
      REG_MODE_COUNT:        modes_reg  = d[MODE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic send_frame(input in_word_t w, input logic known, input out_word_t want);
    out_word_t pred;
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_frame(w);
    frame_q.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  // wait for every expected word, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic report(input string what, input out_word_t w, input out_word_t g);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at cycle %0d", what, cycle_count);
      $display("  want r%0d p%0d y%0d t%0d b%0d aux%b%b%b%b lock%b mode%0d",
               w.roll_out, w.pitch_out, w.yaw_out, w.thrust_out, w.battery_out,
               w.aux_one, w.aux_two, w.aux_three, w.aux_four, w.locked, w.flight_mode);
      $display("  got  r%0d p%0d y%0d t%0d b%0d aux%b%b%b%b lock%b mode%0d",
               g.roll_out, g.pitch_out, g.yaw_out, g.thrust_out, g.battery_out,
               g.aux_one, g.aux_two, g.aux_three, g.aux_four, g.locked, g.flight_mode);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (frame_q.size() == 0) begin
        report("unexpected word", '0, out_data);
      end else begin
        head_w = frame_q.pop_front();
        if (out_data.roll_out !== head_w.roll_out || out_data.pitch_out !== head_w.pitch_out ||
            out_data.yaw_out !== head_w.yaw_out || out_data.thrust_out !== head_w.thrust_out ||
            out_data.battery_out !== head_w.battery_out ||
            out_data.aux_one !== head_w.aux_one || out_data.aux_two !== head_w.aux_two ||
            out_data.aux_three !== head_w.aux_three || out_data.aux_four !== head_w.aux_four ||
            out_data.locked !== head_w.locked || out_data.flight_mode !== head_w.flight_mode)
          report("word mismatch", head_w, out_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL rc_stick_frame_conditioner_core");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off once traffic is flowing
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!held && words_seen >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_write  = 1'b0;
    cfg_index  = REG_CENTER_VALUE;
    cfg_data   = '0;
    calm       = 1'b0;
    center_reg = CENTER_RESET;
    limit_reg  = LOCK_LIMIT_RESET;
    modes_reg  = MODE_COUNT_RESET;
    trim_armed = 1'b1;
    roll_ofs   = '0;
    pitch_ofs  = '0;
    yaw_ofs    = '0;
    prev_b1    = 1'b0;
    prev_b3    = 1'b0;
    lock_st    = 1'b0;
    mode_st    = MODE_FIRST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NDIR; i++)
      send_frame(DIR_TAB[i].frame, DIR_TAB[i].known, DIR_TAB[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      calm = (ph == CALM_PHASE);
      @(negedge clk);
      case (ph)
        0: begin
          write_reg(REG_CENTER_VALUE, 12'd0);
          write_reg(REG_LOCK_THRUST_LIMIT, 12'd0);
          write_reg(REG_MODE_COUNT, 12'd1);
        end
        1: begin
          write_reg(REG_CENTER_VALUE, 12'd3000);
          write_reg(REG_LOCK_THRUST_LIMIT, 12'd1000);
          write_reg(REG_MODE_COUNT, 12'd7);
        end
        2: begin
          write_reg(REG_CENTER_VALUE, 12'd4095);
          write_reg(REG_LOCK_THRUST_LIMIT, 12'd1023);
          write_reg(REG_MODE_COUNT, 12'd0);
        end
        3: begin
          write_reg(REG_MODE_COUNT, CFG_DATA_W'($urandom_range(7, 1)));
          write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(4095)));
          write_reg(REG_CENTER_VALUE, CFG_DATA_W'($urandom_range(3000)));
          write_reg(REG_LOCK_THRUST_LIMIT, CFG_DATA_W'($urandom_range(1000)));
        end
        4: begin
          write_reg(REG_CENTER_VALUE, 12'd1500);
          write_reg(REG_LOCK_THRUST_LIMIT, 12'd10);
          write_reg(REG_MODE_COUNT, 12'd3);
        end
        default: begin
          write_reg(REG_CENTER_VALUE, CFG_DATA_W'($urandom_range(4095)));
          write_reg(REG_LOCK_THRUST_LIMIT, CFG_DATA_W'($urandom_range(4095)));
          write_reg(REG_MODE_COUNT, CFG_DATA_W'($urandom_range(4095)));
        end
      endcase
      cfg_write <= 1'b0;
      for (int n = 0; n < PHASE_WORDS; n++)
        send_frame(make_frame(), 1'b0, '0);
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS rc_stick_frame_conditioner_core");
    end else begin
      $display("FAIL rc_stick_frame_conditioner_core");
    end
    $finish;
  end

endmodule
